[rtl/core/triangle_texture_coord_setup_assert.svh]
// Assertion macros for the triangle texture setup block.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef TRIANGLE_TEXTURE_COORD_SETUP_ASSERT_SVH
`define TRIANGLE_TEXTURE_COORD_SETUP_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define TCS_ASSERT_COMB(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent now implies consequent in the next cycle
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tcs_pkg.sv]
// Shared widths, latencies and datapath step functions for the
// triangle texture setup pipeline. No dependencies.
`default_nettype none

package tcs_pkg;

  localparam int FracBits = 16;
  localparam int CoordW   = 32;
  localparam int NumCoord = 9;
  localparam int SqW      = 66;               // exact squared side length
  localparam int NumW     = 67;               // |b^2 + c^2 - a^2|
  localparam int RootW    = SqW / 2;          // floor sqrt of SqW bits
  localparam int RemSqW   = RootW + 2;
  localparam int DivDW    = RootW + 1;        // divisor width (2c)
  localparam int DivRemW  = DivDW + 1;
  localparam int DivQW    = RootW + FracBits; // quotient bits per divide
  localparam int QW       = RootW + 1;        // law-of-cosines x0 width
  localparam int OutUW    = 32;
  localparam int OutPW    = 31;

  localparam int DistLat  = 3;
  localparam int SqrtLat  = RootW;
  localparam int DivLat   = DivQW;
  localparam int PipeLat  = DistLat + SqrtLat + DivLat + 2 + SqrtLat + DivLat;

  localparam logic CfgLenS = 1'b0;
  localparam logic CfgLenT = 1'b1;

  typedef struct packed {
    logic [RemSqW-1:0] rem;
    logic [RootW-1:0]  root;
  } sq_step_t;

  typedef struct packed {
    logic [DivRemW-1:0] rem;
    logic               bit_q;
  } div_step_t;

  function automatic sq_step_t sqrt_step(input logic [RemSqW-1:0] rem,
                                         input logic [RootW-1:0]  root,
                                         input logic [1:0]        pair);
    logic [RemSqW-1:0] t;
    logic [RemSqW-1:0] trial;
    sq_step_t          r;
    t     = {rem[RemSqW-3:0], pair};
    trial = {root, 2'b01};
    if (t >= trial) begin
      r.rem  = t - trial;
      r.root = {root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = t;
      r.root = {root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_step_t div_step(input logic [DivRemW-1:0] rem,
                                         input logic [DivDW-1:0]   den,
                                         input logic               nbit);
    logic [DivRemW-1:0] t;
    logic [DivRemW-1:0] dd;
    div_step_t          r;
    t  = {rem[DivRemW-2:0], nbit};
    dd = {1'b0, den};
    if (t >= dd) begin
      r.rem   = t - dd;
      r.bit_q = 1'b1;
    end else begin
      r.rem   = t;
      r.bit_q = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tcs_dist.sv]
// Squared side lengths of the triangle, three register stages.
// Depends on tcs_pkg.
`default_nettype none

module tcs_dist
  import tcs_pkg::*;
(
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic [NumCoord-1:0][CoordW-1:0]    coord_i,
  output logic      [SqW-1:0]                     sa_o,
  output logic      [SqW-1:0]                     sb_o,
  output logic      [SqW-1:0]                     sc_o
);

  // side j uses corners (pi, qi): a = (0,2), b = (1,0), c = (2,1)
  logic [8:0][CoordW-1:0]   abs_d, abs_q;
  logic [8:0][2*CoordW-1:0] sq_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        logic [CoordW:0] p, q, d;
        p = {coord_i[(j == 0 ? 0 : (j == 1 ? 1 : 2)) * 3 + k][CoordW-1],
             coord_i[(j == 0 ? 0 : (j == 1 ? 1 : 2)) * 3 + k]};
        q = {coord_i[(j == 0 ? 2 : (j == 1 ? 0 : 1)) * 3 + k][CoordW-1],
             coord_i[(j == 0 ? 2 : (j == 1 ? 0 : 1)) * 3 + k]};
        d = p - q;
        if (d[CoordW]) d = (~d) + 1'b1;
        abs_d[j*3+k] = d[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q <= abs_d;
      for (int i = 0; i < 9; i++) sq_q[i] <= abs_q[i] * abs_q[i];
      sa_o <= SqW'(sq_q[0]) + SqW'(sq_q[1]) + SqW'(sq_q[2]);
      sb_o <= SqW'(sq_q[3]) + SqW'(sq_q[4]) + SqW'(sq_q[5]);
      sc_o <= SqW'(sq_q[6]) + SqW'(sq_q[7]) + SqW'(sq_q[8]);
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcs_sqrt.sv]
// Floor square root, one result bit per register stage.
// Depends on tcs_pkg.
`default_nettype none

module tcs_sqrt
  import tcs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [SqW-1:0]   rad_i,
  output logic      [RootW-1:0] root_o
);

  logic [SqW-1:0]    rad_q  [SqrtLat-1];
  logic [RemSqW-1:0] rem_q  [SqrtLat-1];
  logic [RootW-1:0]  root_q [SqrtLat];

  for (genvar i = 0; i < SqrtLat; i++) begin : g_stage
    logic [SqW-1:0]    rad_in;
    logic [RemSqW-1:0] rem_in;
    logic [RootW-1:0]  root_in;
    sq_step_t          step;

    if (i == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign step = sqrt_step(rem_in, root_in, rad_in[SqW-1:SqW-2]);

    always_ff @(posedge clk_i) begin
      if (en_i) root_q[i] <= step.root;
    end

    if (i < SqrtLat - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= step.rem;
          rad_q[i] <= {rad_in[SqW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[SqrtLat-1];

endmodule

`default_nettype wire

[rtl/core/tcs_div.sv]
// Restoring divider, one quotient bit per register stage.
// Quotient must fit DivQW bits. Depends on tcs_pkg.
`default_nettype none

module tcs_div
  import tcs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [NumW-1:0]   num_i,
  input  wire logic [DivDW-1:0]  den_i,
  output logic      [DivQW-1:0]  quo_o
);

  // low numerator bits shift out the top while quotient bits shift in below
  logic [DivQW-1:0]   lo_q  [DivLat];
  logic [DivRemW-1:0] rem_q [DivLat-1];
  logic [DivDW-1:0]   den_q [DivLat-1];

  for (genvar i = 0; i < DivLat; i++) begin : g_stage
    logic [DivQW-1:0]   lo_in;
    logic [DivRemW-1:0] rem_in;
    logic [DivDW-1:0]   den_in;
    div_step_t          step;

    if (i == 0) begin : g_first
      assign lo_in  = num_i[DivQW-1:0];
      assign rem_in = DivRemW'(num_i[NumW-1:DivQW]);
      assign den_in = den_i;
    end else begin : g_next
      assign lo_in  = lo_q[i-1];
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
    end

    assign step = div_step(rem_in, den_in, lo_in[DivQW-1]);

    always_ff @(posedge clk_i) begin
      if (en_i) lo_q[i] <= {lo_in[DivQW-2:0], step.bit_q};
    end

    if (i < DivLat - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= step.rem;
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo_o = lo_q[DivLat-1];

endmodule

`default_nettype wire

[rtl/core/triangle_texture_coord_setup.sv]
// Top level of the triangle texture setup pipeline.
// Depends on tcs_pkg, tcs_dist, tcs_sqrt, tcs_div and the assert macros.
`default_nettype none
`include "triangle_texture_coord_setup_assert.svh"

// Flattens one 3-D triangle per request into texture space. A new triangle
// is taken every cycle unless the pipeline holds; each result passes through
// the squared distances, two 33-stage square roots, two 49-stage dividers in
// series and two stages for x0^2 and y0^2. A two-entry output buffer takes
// results while the sink stalls; the whole pipeline holds only when that
// buffer is full. Repeat lengths may be written only while no triangle is in
// flight.
module triangle_texture_coord_setup
  import tcs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z
  input  wire logic [287:0] s_axis_tdata,
  // has_texture
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // apex_u[31:0], apex_v[62:32], far_u[93:63], zero pad
  output logic [95:0]       m_axis_tdata,
  // degenerate
  output logic              m_axis_tuser
);

  typedef struct packed {
    logic            deg;
    logic            neg;
    logic            tex;
    logic [NumW-1:0] num;
    logic [SqW-1:0]  sb;
  } seg_a_t;

  typedef struct packed {
    logic             deg;
    logic             neg;
    logic             tex;
    logic [SqW-1:0]   sb;
    logic [RootW-1:0] c;
  } seg_b_t;

  typedef struct packed {
    logic             deg;
    logic             neg;
    logic             tex;
    logic [QW-1:0]    q;
    logic [RootW-1:0] c;
    logic [DivQW-1:0] s;
  } seg_c_t;

  typedef struct packed {
    seg_c_t           side;
    logic [RootW-1:0] y0;
  } seg_d_t;

  typedef struct packed {
    logic             deg;
    logic [OutPW-1:0] fu;
    logic [OutPW-1:0] av;
    logic [OutUW-1:0] au;
  } out_t;

  localparam logic [OutPW-1:0] PosMax = '1;

  logic [31:0] len_s_q, len_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_s_q <= 32'd65536;
      len_t_q <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLenS: len_s_q <= cfg_data_i;
        CfgLenT: len_t_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance and output buffer
  logic       en, push, pop;
  logic [1:0] fifo_cnt_q;
  logic       wr_q, rd_q;
  out_t       ent_q [2];
  out_t       res;
  logic [PipeLat-1:0] v_q;
  logic               tex_q [DistLat];

  assign en            = (fifo_cnt_q != 2'd2);
  assign s_axis_tready = en;
  assign push          = en && v_q[PipeLat-1];
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PipeLat-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tex_q[0] <= s_axis_tuser;
      for (int i = 1; i < DistLat; i++) tex_q[i] <= tex_q[i-1];
    end
  end

  // squared side lengths
  logic [SqW-1:0] sa, sb, sc;

  tcs_dist u_dist (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (s_axis_tdata),
    .sa_o    (sa),
    .sb_o    (sb),
    .sc_o    (sc)
  );

  // c = sqrt(c^2), with the cosine numerator waiting alongside
  seg_a_t           a_d;
  seg_a_t           dly_a_q [SqrtLat];
  logic [NumW-1:0]  sum_bc;
  logic [RootW-1:0] c_root;

  assign sum_bc = NumW'(sb) + NumW'(sc);

  always_comb begin
    a_d.deg = (sa == '0) || (sb == '0) || (sc == '0);
    a_d.neg = sum_bc < NumW'(sa);
    a_d.tex = tex_q[DistLat-1];
    a_d.num = a_d.neg ? (NumW'(sa) - sum_bc) : (sum_bc - NumW'(sa));
    a_d.sb  = sb;
  end

  tcs_sqrt u_sqrt_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sc),
    .root_o (c_root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_a_q[0] <= a_d;
      for (int i = 1; i < SqrtLat; i++) dly_a_q[i] <= dly_a_q[i-1];
    end
  end

  // x0 = num / 2c, and s = c / length_s in parallel
  seg_b_t           b_d;
  seg_b_t           dly_b_q [DivLat];
  logic [DivQW-1:0] quo_x, quo_s;

  always_comb begin
    b_d.deg = dly_a_q[SqrtLat-1].deg;
    b_d.neg = dly_a_q[SqrtLat-1].neg;
    b_d.tex = dly_a_q[SqrtLat-1].tex;
    b_d.sb  = dly_a_q[SqrtLat-1].sb;
    b_d.c   = c_root;
  end

  tcs_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (dly_a_q[SqrtLat-1].num),
    .den_i ({c_root, 1'b0}),
    .quo_o (quo_x)
  );

  tcs_div u_div_s (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (NumW'({c_root, {FracBits{1'b0}}})),
    .den_i (DivDW'(len_s_q)),
    .quo_o (quo_s)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_b_q[0] <= b_d;
      for (int i = 1; i < DivLat; i++) dly_b_q[i] <= dly_b_q[i-1];
    end
  end

  // y0^2 = b^2 - x0^2, clamped at zero
  seg_c_t          m_side_q, y_side_q;
  logic [SqW-1:0]  m_sb_q;
  logic [2*QW-1:0] xsq_q;
  logic [SqW-1:0]  ysq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_side_q.deg <= dly_b_q[DivLat-1].deg;
      m_side_q.neg <= dly_b_q[DivLat-1].neg;
      m_side_q.tex <= dly_b_q[DivLat-1].tex;
      m_side_q.q   <= quo_x[QW-1:0];
      m_side_q.c   <= dly_b_q[DivLat-1].c;
      m_side_q.s   <= quo_s;
      m_sb_q       <= dly_b_q[DivLat-1].sb;
      xsq_q        <= quo_x[QW-1:0] * quo_x[QW-1:0];
      y_side_q     <= m_side_q;
      if ((2*QW)'(m_sb_q) < xsq_q) ysq_q <= '0;
      else                         ysq_q <= SqW'((2*QW)'(m_sb_q) - xsq_q);
    end
  end

  // y0 = sqrt(y0^2), then t = y0 / length_t
  logic [RootW-1:0] y0_root;
  logic [DivQW-1:0] quo_t;
  seg_c_t           dly_c_q [SqrtLat];
  seg_d_t           d_d;
  seg_d_t           dly_d_q [DivLat];

  tcs_sqrt u_sqrt_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (ysq_q),
    .root_o (y0_root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_c_q[0] <= y_side_q;
      for (int i = 1; i < SqrtLat; i++) dly_c_q[i] <= dly_c_q[i-1];
    end
  end

  assign d_d.side = dly_c_q[SqrtLat-1];
  assign d_d.y0   = y0_root;

  tcs_div u_div_t (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (NumW'({y0_root, {FracBits{1'b0}}})),
    .den_i (DivDW'(len_t_q)),
    .quo_o (quo_t)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_d_q[0] <= d_d;
      for (int i = 1; i < DivLat; i++) dly_d_q[i] <= dly_d_q[i-1];
    end
  end

  // output selection and saturation
  function automatic logic [OutPW-1:0] sat_pos(input logic [DivQW-1:0] v);
    if (v > DivQW'(PosMax)) return PosMax;
    return v[OutPW-1:0];
  endfunction

  seg_d_t fin;
  assign fin = dly_d_q[DivLat-1];

  always_comb begin
    res = '0;
    if (!fin.side.deg) begin
      if (fin.side.tex) begin
        res.au = {1'b0, sat_pos({1'b0, fin.side.s[DivQW-1:1]})};
        res.av = sat_pos(quo_t);
        res.fu = sat_pos(fin.side.s);
      end else begin
        if (fin.side.neg) begin
          // negated x0, clamped at the most negative value
          if (fin.side.q > QW'(33'h1_0000_0000 >> 1)) res.au = 32'h8000_0000;
          else res.au = (~fin.side.q[OutUW-1:0]) + 32'd1;
        end else begin
          res.au = {1'b0, sat_pos(DivQW'(fin.side.q))};
        end
        res.av = sat_pos(DivQW'(fin.y0));
        res.fu = sat_pos(DivQW'(fin.side.c));
      end
    end
    res.deg = fin.side.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= 2'd0;
      wr_q       <= 1'b0;
      rd_q       <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      fifo_cnt_q <= fifo_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= res;
  end

  assign m_axis_tvalid = (fifo_cnt_q != 2'd0);
  assign m_axis_tdata  = {2'b00, ent_q[rd_q].fu, ent_q[rd_q].av, ent_q[rd_q].au};
  assign m_axis_tuser  = ent_q[rd_q].deg;

  `TCS_ASSERT_COMB(a_buf_no_overflow, !(push && !pop && fifo_cnt_q == 2'd2), "output buffer overflow")
  `TCS_ASSERT_NEXT(a_accept_tracked, s_axis_tvalid && s_axis_tready, v_q[0], "accepted request lost")
  `TCS_ASSERT_COMB(a_degenerate_zero, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata == '0), "degenerate result carries data")

endmodule

`default_nettype wire

[bench/triangle_texture_coord_setup_test.sv]
// Self-checking testbench for triangle_texture_coord_setup.
// Drives triangles on the slave stream, predicts each result and compares it
// with the master stream. Needs tcs_pkg and the block's RTL only.
`timescale 1ns / 1ps

module triangle_texture_coord_setup_test
  import tcs_pkg::*;
();

  typedef struct packed {
    logic [31:0] apex_u;
    logic [30:0] apex_v;
    logic [30:0] far_u;
    logic        degenerate;
  } coord_res_t;

  typedef struct packed {
    logic [8:0][31:0] crd;
    logic             tex;
    logic             known;
    coord_res_t       res;
  } tri_row_t;

  localparam int NumRows  = 14;
  localparam int PhaseLen = 275;
  localparam int Drain    = 220;
  localparam int HoldLen  = 400;
  localparam logic [63:0] Max64  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PosMax = 64'h7FFF_FFFF;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;

  logic [31:0] len_s;
  logic [31:0] len_t;
  coord_res_t  pending_q[$];
  int          errors = 0;
  int          table_errors = 0;
  int          idle_pct;
  int          stall_pct;
  logic        hold_go;
  logic        hold_on;
  tri_row_t    rows[NumRows];

  triangle_texture_coord_setup i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      sq   = {64'd0, cand} * {64'd0, cand};
      if (n >= sq) r = cand;
    end
    return r;
  endfunction

  function automatic logic [127:0] side_sq(input logic [8:0][31:0] crd, input int i,
                                           input int j);
    logic [127:0] s;
    logic [63:0]  d;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      d = 64'($signed(crd[i*3+k])) - 64'($signed(crd[j*3+k]));
      if (d[63]) d = -d;
      s += {64'd0, d} * {64'd0, d};
    end
    return s;
  endfunction

  function automatic logic [63:0] tex_scale(input logic [63:0] v, input logic [31:0] len);
    if (len == 0) return Max64;
    return (v << FracBits) / {32'd0, len};
  endfunction

  function automatic logic [63:0] clip_pos(input logic [63:0] v);
    return (v > PosMax) ? PosMax : v;
  endfunction

  function automatic coord_res_t flatten_triangle(input logic [8:0][31:0] crd,
                                                  input logic tex);
    logic [127:0] sa, sb, sc, num, quo, xsq, ysq;
    logic [63:0]  c, q, y0, s, t, au, av, fu;
    logic         neg;
    coord_res_t   r;
    sa = side_sq(crd, 0, 2);
    sb = side_sq(crd, 1, 0);
    sc = side_sq(crd, 2, 1);
    r  = '0;
    if (sa == 0 || sb == 0 || sc == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    c   = floor_sqrt(sc);
    num = sb + sc;
    neg = num < sa;
    num = neg ? sa - num : num - sa;
    quo = num / ({64'd0, c} << 1);
    q   = (quo[127:64] != 0) ? Max64 : quo[63:0];
    xsq = {64'd0, q} * {64'd0, q};
    ysq = (sb < xsq) ? '0 : sb - xsq;
    y0  = floor_sqrt(ysq);
    if (tex) begin
      s  = tex_scale(c, len_s);
      t  = tex_scale(y0, len_t);
      au = clip_pos(s >> 1);
      av = clip_pos(t);
      fu = clip_pos(s);
    end else begin
      if (neg) au = (q > 64'h8000_0000) ? 64'h8000_0000 : ((64'h1_0000_0000 - q) & 64'hFFFF_FFFF);
      else au = clip_pos(q);
      av = clip_pos(y0);
      fu = clip_pos(c);
    end
    r.apex_u = au[31:0];
    r.apex_v = av[30:0];
    r.far_u  = fu[30:0];
    return r;
  endfunction

  function automatic tri_row_t mk_row(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                      input logic tex, input logic known);
    tri_row_t r;
    r        = '0;
    r.crd[0] = ax; r.crd[1] = ay; r.crd[2] = az;
    r.crd[3] = bx; r.crd[4] = by; r.crd[5] = bz;
    r.crd[6] = cx; r.crd[7] = cy; r.crd[8] = cz;
    r.tex    = tex;
    r.known  = known;
    r.res.degenerate = known;  // only degenerate rows carry a typed-in result
    return r;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_lengths(input logic [31:0] s, input logic [31:0] t);
    write_reg(CfgLenS, s);
    write_reg(CfgLenT, t);
    len_s = s;
    len_t = t;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic send_tri(input logic [8:0][31:0] crd, input logic tex);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= crd;
    s_axis_tuser  <= tex;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [31:0] rand_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097151)) - 1048576);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(255)) - 128) <<< 16;
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [8:0][31:0] crd;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(3);
      for (int k = 0; k < 9; k++) crd[k] = rand_coord(kind);
      case ($urandom_range(19))
        0: for (int k = 0; k < 3; k++) crd[k] = crd[3+k];       // shared corner
        1: for (int k = 0; k < 3; k++) crd[k] = (crd[3+k] + crd[6+k]) >>> 1;  // collinear-ish
        2: if (n % 50 == 0) hold_go <= ~hold_go;
        default: ;
      endcase
      send_tri(crd, $urandom_range(1));
    end
  endtask

  // request capture: each accepted triangle yields one expected result
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_q.insert(pending_q.size(), flatten_triangle(s_axis_tdata, s_axis_tuser));
  end

  always @(posedge clk_i) begin
    coord_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== want.apex_u) begin
          $error("apex_u exp %h got %h", want.apex_u, m_axis_tdata[31:0]); errors++;
        end
        if (m_axis_tdata[62:32] !== want.apex_v) begin
          $error("apex_v exp %h got %h", want.apex_v, m_axis_tdata[62:32]); errors++;
        end
        if (m_axis_tdata[93:63] !== want.far_u) begin
          $error("far_u exp %h got %h", want.far_u, m_axis_tdata[93:63]); errors++;
        end
        if (m_axis_tuser !== want.degenerate) begin
          $error("degenerate exp %b got %b", want.degenerate, m_axis_tuser); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  // long sink hold-off so the pipeline backs up into the input;
  // a change of hold_go asks for one
  initial begin
    logic hold_seen;
    hold_seen = 1'b0;
    hold_on   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_on <= 1'b1;
        repeat (HoldLen) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    hold_go       = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    len_s         = 32'h0001_0000;
    len_t         = 32'h0001_0000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows[0]  = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
    rows[1]  = mk_row(5, 6, 7, 5, 6, 7, 9, 9, 9, 1'b1, 1'b1);             // first on second
    rows[2]  = mk_row(1, 2, 3, 4, 5, 6, 4, 5, 6, 1'b0, 1'b1);             // third on second
    rows[3]  = mk_row(0, 65536, 0, 0, 0, 0, 65536, 0, 0, 1'b0, 1'b0);     // right angle
    rows[4]  = mk_row(0, 65536, 0, 0, 0, 0, 65536, 0, 0, 1'b1, 1'b0);
    rows[5]  = mk_row(-65536, 65536, 0, 0, 0, 0, 65536, 0, 0, 1'b0, 1'b0); // apex behind origin
    rows[6]  = mk_row(65536, 1, 0, 0, 0, 0, 131072, 0, 0, 1'b0, 1'b0);    // near collinear
    rows[7]  = mk_row(2, 2, 2, 0, 0, 0, 4, 4, 4, 1'b0, 1'b0);             // exactly collinear
    rows[8]  = mk_row(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0);
    rows[9]  = mk_row(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0);
    rows[10] = mk_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0);
    rows[11] = mk_row(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFE, 1, 0, 1'b0, 1'b0);
    rows[12] = mk_row(-1, -1, -1, 0, 0, 0, 1, 0, 0, 1'b1, 1'b0);
    rows[13] = mk_row(-1, -1, -1, -1, -1, -1, 0, 0, 0, 1'b1, 1'b1);

    set_lengths(32'h0001_0000, 32'h0001_0000);
    for (int i = 0; i < NumRows; i++) begin
      if (rows[i].known && flatten_triangle(rows[i].crd, rows[i].tex) !== rows[i].res) begin
        $error("directed row %0d table entry disagrees with prediction", i);
        table_errors++;
      end
      send_tri(rows[i].crd, rows[i].tex);
    end
    wait_idle();

    set_lengths(32'd1, 32'hFFFF_FFFF);
    idle_pct = 65; stall_pct = 0;
    send_random(PhaseLen);
    wait_idle();

    set_lengths(32'hFFFF_FFFF, 32'd1);
    idle_pct = 0; stall_pct = 65;
    hold_go <= ~hold_go;
    send_random(PhaseLen);
    wait_idle();

    set_lengths($urandom_range(32'h0004_0000, 1), $urandom_range(32'h0004_0000, 1));
    idle_pct = 36; stall_pct = 36;
    send_random(PhaseLen);
    wait_idle();

    set_lengths(32'h0001_0000, 32'h0001_0000);
    idle_pct = 0; stall_pct = 0;
    send_random(PhaseLen);
    wait_idle();

    if (errors == 0 && table_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tcs_pkg.sv
rtl/core/tcs_dist.sv
rtl/core/tcs_sqrt.sv
rtl/core/tcs_div.sv
rtl/core/triangle_texture_coord_setup.sv
bench/triangle_texture_coord_setup_test.sv
